@@ design/sil_pkg.sv @@
// Package: shared types and constants of the sorted insertion list unit.
package sil_pkg;

  localparam int CAPACITY = 64;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } sil_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } sil_status_e;

  typedef struct packed {
    sil_cmd_e                   cmd;
    logic signed [VALUE_W-1:0]  value;
    logic        [IDX_W-1:0]    index;
  } sil_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  read_value;
    logic        [COUNT_W-1:0]  count;
    sil_status_e                status;
  } sil_out_t;

  // Insert broadcast seen by every cell of the chain.
  typedef struct packed {
    logic                       en;
    logic signed [VALUE_W-1:0]  value;
  } sil_bcast_t;

endpackage

@@ design/sil_cell.sv @@
// Module: one compare-and-shift cell of the sorted list chain.
module sil_cell (
  input  logic                               clk_i,
  input  sil_pkg::sil_bcast_t                bcast_i,
  input  logic                               occupied_i,
  input  logic                               prev_take_i,
  input  logic signed [sil_pkg::VALUE_W-1:0] prev_value_i,
  output logic                               take_o,
  output logic signed [sil_pkg::VALUE_W-1:0] value_o
);

  logic signed [sil_pkg::VALUE_W-1:0] value_q;
  logic signed [sil_pkg::VALUE_W-1:0] value_d;

  // Cell is at or past the insert position: empty, or holds a value >= new one.
  assign take_o = !occupied_i || (value_q >= bcast_i.value);

  always_comb begin
    value_d = value_q;
    if (bcast_i.en) begin
      if (prev_take_i) begin
        value_d = prev_value_i;   // shift up from the neighbour
      end else if (take_o) begin
        value_d = bcast_i.value;  // first taking cell holds the new value
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ design/sorted_insertion_list_unit.sv @@
// Module: top level of the sorted insertion list unit.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a chain of
// compare-and-shift cells. Each item is one transfer on the input channel
// and yields exactly one transfer on the output channel. An insert places
// the value before the first stored value greater than or equal to it (or
// at the end); every cell compares against the new value at once and the
// cells at and after the insert position shift up by one place in the same
// clock, so a new item is taken on every cycle while the output register
// is free or being emptied. The rate of one item per cycle rests on the
// compare in each cell and the read selection across all cells being
// combinational. The result is valid in the cycle after the input
// transfer. On a full list an insert is dropped with status full; a read
// at an index at or beyond the count returns zero with status out of
// range. Every result carries the count after the item. After reset the
// list is empty and no clearing is needed.
module sorted_insertion_list_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sil_pkg::sil_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sil_pkg::sil_out_t  out_data_o
);

  localparam int Cap = sil_pkg::CAPACITY;

  logic [sil_pkg::CNT_W-1:0]   count_q;
  logic [sil_pkg::CNT_W-1:0]   count_d;
  logic                        out_valid_q;
  logic                        out_valid_d;
  sil_pkg::sil_out_t           out_data_q;
  sil_pkg::sil_out_t           out_data_d;

  logic                        accept;
  logic                        is_insert;
  logic                        full;
  logic                        in_range;
  sil_pkg::sil_bcast_t         bcast;
  logic signed [sil_pkg::VALUE_W-1:0] rd_value;

  logic [Cap-1:0]                      occupied;
  logic [Cap:0]                        take_chain;
  logic signed [sil_pkg::VALUE_W-1:0]  cell_value [Cap+1];

  // Accept while the output register is empty or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_insert  = (in_data_i.cmd == sil_pkg::CMD_INSERT);
  assign full       = (count_q == sil_pkg::CNT_W'(Cap));

  // Broadcast the insert to every cell; drop it when the list is full.
  assign bcast.en    = accept && is_insert && !full;
  assign bcast.value = in_data_i.value;

  // Head of the chain: nothing shifts into the first cell.
  assign take_chain[0] = 1'b0;
  assign cell_value[0] = '0;

  for (genvar g = 0; g < Cap; g++) begin : g_cell
    assign occupied[g] = (sil_pkg::CNT_W'(g) < count_q);

    sil_cell u_cell (
      .clk_i        (clk_i),
      .bcast_i      (bcast),
      .occupied_i   (occupied[g]),
      .prev_take_i  (take_chain[g]),
      .prev_value_i (cell_value[g]),
      .take_o       (take_chain[g+1]),
      .value_o      (cell_value[g+1])
    );
  end

  // Read selection: index below count only, so the cell is always written.
  assign in_range = (sil_pkg::CMP_W'(in_data_i.index) < sil_pkg::CMP_W'(count_q));

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < Cap; i++) begin
      if (sil_pkg::CMP_W'(in_data_i.index) == sil_pkg::CMP_W'(i)) begin
        rd_value = rd_value | cell_value[i+1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (bcast.en) begin
      count_d = count_q + sil_pkg::CNT_W'(1);
    end
  end

  // Build the result of the item being accepted.
  always_comb begin
    out_data_d            = out_data_q;
    out_data_d.read_value = '0;
    out_data_d.count      = sil_pkg::COUNT_W'(count_d);
    out_data_d.status     = sil_pkg::ST_OK;
    if (is_insert) begin
      if (full) begin
        out_data_d.status = sil_pkg::ST_FULL;
      end
    end else if (in_range) begin
      out_data_d.read_value = rd_value;
    end else begin
      out_data_d.status = sil_pkg::ST_RANGE;
    end
  end

  // Hold the result until the output transfer; load on every input transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ design/sil_checker.sv @@
// Checker: port-level assertions for the sorted insertion list unit, with bind.
module sil_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input sil_pkg::sil_in_t   in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sil_pkg::sil_out_t  out_data_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Full status only with a full list.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == sil_pkg::ST_FULL
      |-> out_data_o.count == sil_pkg::COUNT_W'(sil_pkg::CAPACITY))
    else $error("full status with list not full");

  // A failed item yields zero.
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != sil_pkg::ST_OK |-> out_data_o.read_value == '0)
    else $error("nonzero value on a failed item");

  // A transfer in always produces a result on the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after an input transfer");

  // A read yields only an ok or a range status, never an insert status.
  a_range_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.cmd == sil_pkg::CMD_READ
      |=> out_data_o.status == sil_pkg::ST_OK || out_data_o.status == sil_pkg::ST_RANGE)
    else $error("read gave an insert status");

endmodule

bind sorted_insertion_list_unit sil_port_checker u_sil_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
